// ----- rtl/lbbs_pkg.sv -----
// Shared types and constants for the LED burst blink scheduler.
package lbbs_pkg;

    // Opcodes of an input item
    localparam logic [2:0] OP_ADVANCE = 3'd0;
    localparam logic [2:0] OP_SERVICE = 3'd1;
    localparam logic [2:0] OP_START   = 3'd2;
    localparam logic [2:0] OP_STOP    = 3'd3;
    localparam logic [2:0] OP_ONCE    = 3'd4;
    localparam logic [2:0] OP_STEADY  = 3'd5;

    // Result status codes
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_WAIT    = 3'd1;
    localparam logic [2:0] ST_TOGGLED = 3'd2;
    localparam logic [2:0] ST_ACCEPT  = 3'd3;
    localparam logic [2:0] ST_IGNORE  = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_ON    = 2'd0;
    localparam logic [1:0] REG_OFF   = 2'd1;
    localparam logic [1:0] REG_SLEEP = 2'd2;
    localparam logic [1:0] REG_ONCE  = 2'd3;

    // Configuration reset values
    localparam logic [15:0] RST_ON_MS    = 16'd100;
    localparam logic [15:0] RST_OFF_MS   = 16'd200;
    localparam logic [15:0] RST_SLEEP_MS = 16'd1000;
    localparam logic [15:0] RST_ONCE_MS  = 16'd100;

    typedef enum logic [2:0] {
        PH_OFF   = 3'd0,
        PH_ON    = 3'd1,
        PH_SLEEP = 3'd2,
        PH_ONCE  = 3'd3,
        PH_KEEP  = 3'd4
    } t_phase;

    typedef struct packed {
        logic [15:0] on_ms;
        logic [15:0] off_ms;
        logic [15:0] sleep_ms;
        logic [15:0] once_ms;
    } t_delays;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [1:0]  channel;
        logic [14:0] burst_flashes;
        logic [1:0]  priority_req;
        logic        level_flag;
    } t_item;

    typedef struct packed {
        logic [1:0] channel_out;
        logic       led_level;
        logic [2:0] status;
    } t_result;

endpackage

// ----- rtl/led_burst_blink_scheduler_unit.sv -----
// LED burst blink scheduler: top level with input and result registers.
//
// Input channel: i_valid/o_stall carry one command item (opcode, channel,
// burst flashes, priority, level flag); a transfer happens on a rising edge
// with i_valid high and o_stall low. Output channel: o_valid/i_stall carry
// one result (channel, driven LED level, status) per item, in order.
// Configuration: i_cfg_we writes i_cfg_data to delay register i_cfg_idx
// (0 on, 1 off, 2 sleep, 3 once time in ms); write only while idle.
// Path: a result passes the input register, then the combinational state
// update into the result register.
// Throughput: one item per cycle; the per-channel state update finishes in
// the same cycle it starts, so items follow back to back unless stalled.
// Reset (i_rst_n low, synchronous) clears the time count, all channel state,
// both pipeline stages, and loads the default delays.
// When the receiver stalls, the result holds; the input register still
// takes one more item, then o_stall rises until the result is taken.
module led_burst_blink_scheduler_unit
    import lbbs_pkg::*;
#(
    parameter int CHANNELS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_opcode,
    input  logic [1:0]  i_channel,
    input  logic [14:0] i_burst_flashes,
    input  logic [1:0]  i_priority_req,
    input  logic        i_level_flag,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_channel_out,
    output logic        o_led_level,
    output logic [2:0]  o_status,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_delays w_dly;
    t_result w_res;
    t_item   r_item;
    t_result r_res;
    logic    r_in_vld;
    logic    r_out_vld;
    logic    w_adv;
    logic    w_take;

    // advance the input stage when the result register is free or drains
    assign w_adv   = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall = r_in_vld && !w_adv;
    assign w_take  = i_valid && !o_stall;

    lbbs_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_delays   (w_dly)
    );

    lbbs_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_adv),
        .i_item  (r_item),
        .i_dly   (w_dly),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.opcode        <= i_opcode;
            r_item.channel       <= i_channel;
            r_item.burst_flashes <= i_burst_flashes;
            r_item.priority_req  <= i_priority_req;
            r_item.level_flag    <= i_level_flag;
        end
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_channel_out = r_res.channel_out;
    assign o_led_level   = r_res.led_level;
    assign o_status      = r_res.status;

endmodule

// ----- rtl/lbbs_cfg_regs.sv -----
// Shared delay configuration registers of the LED burst blink scheduler.
module lbbs_cfg_regs
    import lbbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output t_delays     o_delays
);

    t_delays r_delays;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delays.on_ms    <= RST_ON_MS;
            r_delays.off_ms   <= RST_OFF_MS;
            r_delays.sleep_ms <= RST_SLEEP_MS;
            r_delays.once_ms  <= RST_ONCE_MS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ON:    r_delays.on_ms    <= i_cfg_data;
                REG_OFF:   r_delays.off_ms   <= i_cfg_data;
                REG_SLEEP: r_delays.sleep_ms <= i_cfg_data;
                REG_ONCE:  r_delays.once_ms  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_delays = r_delays;

endmodule

// ----- rtl/lbbs_core.sv -----
// Time count, per-channel blink state and the combinational item update.
module lbbs_core
    import lbbs_pkg::*;
#(
    parameter int CHANNELS = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_delays i_dly,
    output t_result o_res
);

    localparam int         IDXW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [4:0] CH_LIM = 5'(CHANNELS);

    logic [31:0] r_time;
    logic        r_stored [CHANNELS];
    logic        r_driven [CHANNELS];
    logic [1:0]  r_owner  [CHANNELS];
    t_phase      r_phase  [CHANNELS];
    logic [15:0] r_tcount [CHANNELS];
    logic [15:0] r_target [CHANNELS];
    logic [31:0] r_pstart [CHANNELS];

    logic [31:0]     n_time;
    logic            n_stored;
    logic            n_driven;
    logic [1:0]      n_owner;
    t_phase          n_phase;
    logic [15:0]     n_tcount;
    logic [15:0]     n_target;
    logic [31:0]     n_pstart;

    logic [IDXW-1:0] w_idx;
    logic            w_ok;
    logic            w_we;
    logic [15:0]     w_req_target;
    logic [31:0]     w_elapsed;
    logic [15:0]     w_delay;
    logic [15:0]     w_tc_inc;
    logic            w_toggle_lvl;
    logic [2:0]      w_status;

    assign w_idx        = IDXW'(i_item.channel);
    assign w_ok         = {3'b000, i_item.channel} < CH_LIM;
    assign w_req_target = {i_item.burst_flashes, 1'b0};
    assign w_elapsed    = r_time - r_pstart[w_idx];
    assign w_tc_inc     = r_tcount[w_idx] + 16'd1;
    assign w_toggle_lvl = ~r_stored[w_idx];

    always_comb begin
        case (r_phase[w_idx])
            PH_ON:    w_delay = i_dly.on_ms;
            PH_OFF:   w_delay = i_dly.off_ms;
            PH_SLEEP: w_delay = i_dly.sleep_ms;
            PH_ONCE:  w_delay = i_dly.once_ms;
            default:  w_delay = 16'd0;
        endcase
    end

    always_comb begin
        n_time   = r_time;
        n_stored = r_stored[w_idx];
        n_driven = r_driven[w_idx];
        n_owner  = r_owner[w_idx];
        n_phase  = r_phase[w_idx];
        n_tcount = r_tcount[w_idx];
        n_target = r_target[w_idx];
        n_pstart = r_pstart[w_idx];
        w_status = ST_IGNORE;
        case (i_item.opcode)
            OP_ADVANCE: begin
                n_time   = r_time + 32'd1;
                w_status = ST_IDLE;
            end
            OP_SERVICE: begin
                if (r_owner[w_idx] == 2'd0 || r_phase[w_idx] == PH_KEEP) begin
                    w_status = ST_IDLE;
                end else if (w_elapsed < {16'd0, w_delay}) begin
                    w_status = ST_WAIT;
                end else if (r_phase[w_idx] == PH_ONCE) begin
                    // one-shot ends: flip back and release the channel
                    n_stored = w_toggle_lvl;
                    n_driven = w_toggle_lvl;
                    n_owner  = 2'd0;
                    w_status = ST_TOGGLED;
                end else begin
                    n_pstart = r_time;
                    if (r_target[w_idx] != 16'd0 && w_tc_inc >= r_target[w_idx]) begin
                        // burst done: go dark and sleep
                        n_tcount = 16'd0;
                        n_phase  = PH_SLEEP;
                        n_stored = 1'b0;
                        n_driven = 1'b0;
                    end else begin
                        n_tcount = w_tc_inc;
                        n_phase  = w_toggle_lvl ? PH_ON : PH_OFF;
                        n_stored = w_toggle_lvl;
                        n_driven = w_toggle_lvl;
                    end
                    w_status = ST_TOGGLED;
                end
            end
            OP_START: begin
                if (r_owner[w_idx] <= i_item.priority_req) begin
                    n_target = w_req_target;
                    n_phase  = PH_OFF;
                    n_tcount = 16'd0;
                    n_pstart = r_time;
                    n_owner  = i_item.priority_req;
                    w_status = ST_ACCEPT;
                end
            end
            OP_STOP: begin
                if (r_owner[w_idx] == i_item.priority_req &&
                    r_target[w_idx] == w_req_target) begin
                    n_driven = 1'b0;
                    n_owner  = 2'd0;
                    w_status = ST_ACCEPT;
                end
            end
            OP_ONCE: begin
                n_target = 16'd0;
                n_tcount = 16'd0;
                n_owner  = 2'd1;
                n_phase  = PH_ONCE;
                n_pstart = r_time;
                n_stored = i_item.level_flag ? w_toggle_lvl : 1'b1;
                n_driven = n_stored;
                w_status = ST_ACCEPT;
            end
            OP_STEADY: begin
                n_owner  = 2'd1;
                n_phase  = PH_KEEP;
                n_stored = i_item.level_flag;
                n_driven = i_item.level_flag;
                w_status = ST_ACCEPT;
            end
            default: ;
        endcase
        // out-of-range channel: only the time count may move
        if (!w_ok && i_item.opcode != OP_ADVANCE) begin
            w_status = ST_IGNORE;
        end
    end

    assign w_we = i_fire && w_ok && (i_item.opcode != OP_ADVANCE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= 32'd0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_stored[i] <= 1'b0;
                r_driven[i] <= 1'b0;
                r_owner[i]  <= 2'd0;
                r_phase[i]  <= PH_OFF;
                r_tcount[i] <= 16'd0;
                r_target[i] <= 16'd0;
                r_pstart[i] <= 32'd0;
            end
        end else begin
            if (i_fire) begin
                r_time <= n_time;
            end
            if (w_we) begin
                r_stored[w_idx] <= n_stored;
                r_driven[w_idx] <= n_driven;
                r_owner[w_idx]  <= n_owner;
                r_phase[w_idx]  <= n_phase;
                r_tcount[w_idx] <= n_tcount;
                r_target[w_idx] <= n_target;
                r_pstart[w_idx] <= n_pstart;
            end
        end
    end

    assign o_res.channel_out = i_item.channel;
    assign o_res.led_level   = w_ok ? n_driven : 1'b0;
    assign o_res.status      = w_status;

endmodule
